>>> hdl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by every module of the block.
package lkvc_pkg;

  // Default geometry, used as the top level's parameter defaults
  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int OP_BITS    = 2;
  localparam int CAP_BITS   = 5;
  localparam int RES_BITS   = 32;
  localparam int OCC_BITS   = 5;
  localparam int OUT_BITS   = 1 + RES_BITS + 1 + OCC_BITS;
  localparam int OUT_TDATA  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Operation codes
  typedef enum logic [OP_BITS-1:0] {
    OP_GET = 2'd0,
    OP_PUT = 2'd1,
    OP_REM = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic cmp_en;   // register key compare
    logic do_get;   // get step
    logic do_put;   // put step
    logic do_rem;   // remove step
    logic hit_any;  // some valid cell matched
  } cell_ctrl_t;

endpackage

>>> hdl/lkvc_cell.sv
// One rank of the recency chain: key, value and a registered match flag.
// Depends on lkvc_pkg; instanced in a row by lru_key_value_cache.
module lkvc_cell #(
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32,
  parameter int CW         = 5,
  parameter int IDX        = 0
) (
  input  logic                   clk,
  input  lkvc_pkg::cell_ctrl_t   ctrl,
  input  logic [CW-1:0]          count,
  input  logic [KEY_BITS-1:0]    cmp_key,
  input  logic [KEY_BITS-1:0]    left_key,
  input  logic [VALUE_BITS-1:0]  left_value,
  input  logic [KEY_BITS-1:0]    right_key,
  input  logic [VALUE_BITS-1:0]  right_value,
  input  logic                   seen_in,
  input  logic [VALUE_BITS-1:0]  sel_in,
  output logic [KEY_BITS-1:0]    key,
  output logic [VALUE_BITS-1:0]  value,
  output logic                   seen_out,
  output logic [VALUE_BITS-1:0]  sel_out
);
  import lkvc_pkg::*;

  logic match;
  logic valid;
  logic first;
  logic take_left;
  logic take_right;

  // Rank is live when below the entry count
  assign valid = count > CW'(IDX);

  // Match flag, captured in the compare cycle
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      match <= valid && (key == cmp_key);
    end
  end

  // Most recent match: first set flag along the chain
  assign first    = match && !seen_in;
  assign seen_out = seen_in | match;
  assign sel_out  = sel_in | (first ? value : '0);

  // Get moves ranks up to the hit one place back; put moves all back;
  // remove closes the gap from the hit rank onwards
  assign take_left  = ctrl.do_put || (ctrl.do_get && ctrl.hit_any && !seen_in);
  assign take_right = ctrl.do_rem && (seen_in || match);

  always_ff @(posedge clk) begin
    if (take_left) begin
      key   <= left_key;
      value <= left_value;
    end else if (take_right) begin
      key   <= right_key;
      value <= right_value;
    end
  end

endmodule

>>> hdl/lru_key_value_cache.sv
// LRU key/value cache: item sequencer, output register and a row of cells.
// Depends on lkvc_pkg and lkvc_cell.
// Each beat passes the key compare state, then the chain shift state; a new
// beat is taken only as the last one leaves the shift state, and a stalled
// result holds the shift state until taken.
// Reset: synchronous; empties the cache, capacity back to 16, no result.
module lru_key_value_cache #(
  parameter int DEPTH      = lkvc_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF,
  parameter int IN_TDATA   = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration: capacity
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lkvc_pkg::CAP_BITS-1:0]      cfg_data,
  // input beats
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [IN_TDATA-1:0]                s_axis_tdata,  // key, value, zero pad
  input  logic [lkvc_pkg::OP_BITS-1:0]       s_axis_tuser,  // opcode
  // result beats
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lkvc_pkg::OUT_TDATA-1:0]     m_axis_tdata   // found, result_value,
                                                            // evicted, occupancy, pad
);
  import lkvc_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

  state_t                state, state_next;
  op_t                   op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [CW-1:0]         count;
  logic [CAP_BITS-1:0]   capacity;

  logic                  in_fire;
  logic                  exec_fire;
  logic                  out_free;
  logic                  evict;
  logic [CMPW-1:0]       cap_eff;
  cell_ctrl_t            ctrl;

  logic [KEY_BITS-1:0]   cell_key   [DEPTH];
  logic [VALUE_BITS-1:0] cell_val   [DEPTH];
  logic                  seen       [DEPTH+1];
  logic [VALUE_BITS-1:0] sel        [DEPTH+1];
  logic [VALUE_BITS-1:0] ins_value;

  logic                  found;
  logic [RES_BITS-1:0]   res_value;
  logic [OCC_BITS-1:0]   occ;
  logic [CW-1:0]         count_next;

  // Configuration: ready whenever out of reset
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // Handshake
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign exec_fire     = (state == ST_EXEC) && out_free;
  assign s_axis_tready = !rst && ((state == ST_IDLE) || exec_fire);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (in_fire) state_next = ST_CMP;
        else if (exec_fire) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Captured request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= op_t'(s_axis_tuser);
      key_r <= s_axis_tdata[KEY_BITS-1:0];
      val_r <= s_axis_tdata[KEY_BITS +: VALUE_BITS];
    end
  end

  // Capacity clamp: zero acts as one; above depth only a full chain evicts
  assign cap_eff = (capacity == '0) ? CMPW'(1) : CMPW'(capacity);
  assign evict   = (count == CW'(DEPTH)) || (CMPW'(count) >= cap_eff);

  // Cell controls
  always_comb begin
    ctrl         = '0;
    ctrl.cmp_en  = (state == ST_CMP);
    ctrl.do_get  = exec_fire && (op_r == OP_GET);
    ctrl.do_put  = exec_fire && (op_r == OP_PUT);
    ctrl.do_rem  = exec_fire && (op_r == OP_REM);
    ctrl.hit_any = seen[DEPTH];
  end

  assign seen[0]   = 1'b0;
  assign sel[0]    = '0;
  assign ins_value = (op_r == OP_PUT) ? val_r : sel[DEPTH];

  // Row of cells, rank 0 most recent
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]   lk, rk;
    logic [VALUE_BITS-1:0] lv, rv;
    if (i == 0) begin : g_head
      assign lk = key_r;
      assign lv = ins_value;
    end else begin : g_mid
      assign lk = cell_key[i-1];
      assign lv = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rk = cell_key[i];
      assign rv = cell_val[i];
    end else begin : g_body
      assign rk = cell_key[i+1];
      assign rv = cell_val[i+1];
    end
    lkvc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .CW         (CW),
      .IDX        (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .cmp_key     (key_r),
      .left_key    (lk),
      .left_value  (lv),
      .right_key   (rk),
      .right_value (rv),
      .seen_in     (seen[i]),
      .sel_in      (sel[i]),
      .key         (cell_key[i]),
      .value       (cell_val[i]),
      .seen_out    (seen[i+1]),
      .sel_out     (sel[i+1])
    );
  end

  // Entry count and result fields
  always_comb begin
    count_next = count;
    found      = 1'b0;
    res_value  = '0;
    case (op_r)
      OP_GET: begin
        found     = seen[DEPTH];
        res_value = RES_BITS'(sel[DEPTH]);
      end
      OP_PUT: begin
        found     = 1'b1;
        res_value = RES_BITS'(val_r);
        if (!evict) count_next = count + CW'(1);
      end
      OP_REM: begin
        found = seen[DEPTH];
        if (seen[DEPTH]) count_next = count - CW'(1);
      end
      default: begin
        found = 1'b0;
      end
    endcase
  end

  assign occ = OCC_BITS'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_fire) begin
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      m_axis_tdata <= OUT_TDATA'({occ, (op_r == OP_PUT) && evict, res_value, found});
    end
  end

endmodule

>>> hdl/lkvc_checker.sv
// Port-level checks for the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache.
module lkvc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lkvc_pkg::OUT_TDATA-1:0] m_axis_tdata
);
  import lkvc_pkg::*;

  logic                found;
  logic                evicted;
  logic [RES_BITS-1:0] res_value;
  logic [OCC_BITS-1:0] occ;

  assign found     = m_axis_tdata[0];
  assign res_value = m_axis_tdata[RES_BITS:1];
  assign evicted   = m_axis_tdata[RES_BITS+1];
  assign occ       = m_axis_tdata[RES_BITS+2 +: OCC_BITS];

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

  // Eviction only comes from a put, which always reports found
  a_evict_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && evicted |-> found && (occ != '0))
    else $error("eviction without put result");

  // A miss carries no handle
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !found |-> res_value == '0)
    else $error("miss with nonzero handle");

  // Input is never taken during the compare cycle right after a beat
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready in compare cycle");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/lkvc_tb_pkg.sv
// Scoreboard for the LRU key/value cache testbench: a mirror of the cache
// contents and the queue of results still owed. Depends on lkvc_pkg.
`timescale 1ns / 1ps

package lkvc_tb_pkg;
  import lkvc_pkg::*;

  localparam int SLOTS = DEPTH_DEF;
  localparam int KEY_W = KEY_BITS_DEF;
  localparam int VAL_W = VALUE_BITS_DEF;
  localparam int IN_W  = ((KEY_W + VAL_W + 7) / 8) * 8;

  // One result beat as the cache reports it
  typedef struct packed {
    logic                found;
    logic [RES_BITS-1:0] value;
    logic                evicted;
    logic [OCC_BITS-1:0] occupancy;
  } cache_result_t;

  class lru_mirror;
    logic [KEY_W-1:0] keys [SLOTS];
    logic [VAL_W-1:0] vals [SLOTS];
    int               order [SLOTS];  // rank -> slot, rank 0 most recent
    int               count;
    int               capacity;
    cache_result_t    owed_results [$];
    int               errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        order[i] = i;
        keys[i]  = '0;
        vals[i]  = '0;
      end
      count    = 0;
      capacity = int'(CAP_RESET);
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_BITS-1:0] c);
      capacity = int'(c);
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    // most recent rank holding this key, count on a miss
    function int find_rank(logic [KEY_W-1:0] k);
      for (int r = 0; r < count; r++)
        if (keys[order[r]] == k) return r;
      return count;
    endfunction

    // lift the slot at rank src out and drop it in at rank dst
    function void move_rank(int src, int dst);
      int s;
      s = order[src];
      if (src > dst) begin
        for (int i = src; i > dst; i--) order[i] = order[i-1];
      end else begin
        for (int i = src; i < dst; i++) order[i] = order[i+1];
      end
      order[dst] = s;
    endfunction

    // Work out the result of an accepted request and queue it
    function void apply_request(op_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      cache_result_t r;
      int            rank;
      int            cap;
      r   = '0;
      cap = capacity;
      if (cap < 1) cap = 1;
      if (cap > SLOTS) cap = SLOTS;
      case (op)
        OP_GET: begin
          rank = find_rank(k);
          if (rank < count) begin
            move_rank(rank, 0);
            r.found = 1'b1;
            r.value = RES_BITS'(vals[order[0]]);
          end
        end
        OP_PUT: begin
          // reuse the LRU slot when full, else take the first free one
          if ((count + 1 > cap && count > 0) || count >= SLOTS) begin
            move_rank(count - 1, 0);
            r.evicted = 1'b1;
          end else begin
            move_rank(count, 0);
            count++;
          end
          keys[order[0]] = k;
          vals[order[0]] = v;
          r.found = 1'b1;
          r.value = RES_BITS'(v);
        end
        OP_REM: begin
          rank = find_rank(k);
          if (rank < count) begin
            move_rank(rank, count - 1);
            count--;
            r.found = 1'b1;
          end
        end
        default: ;
      endcase
      r.occupancy = OCC_BITS'(count);
      owed_results.push_back(r);
    endfunction

    // Compare a result beat with the oldest owed result
    function void compare_response(logic [OUT_TDATA-1:0] beat);
      cache_result_t got;
      cache_result_t exp;
      got.found     = beat[0];
      got.value     = beat[RES_BITS:1];
      got.evicted   = beat[RES_BITS+1];
      got.occupancy = beat[RES_BITS+2 +: OCC_BITS];
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $time, beat);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.found !== exp.found) begin
        $display("%0t: found expected %0d got %0d", $time, exp.found, got.found);
        errors++;
      end
      if (got.value !== exp.value) begin
        $display("%0t: result_value expected %h got %h", $time, exp.value, got.value);
        errors++;
      end
      if (got.evicted !== exp.evicted) begin
        $display("%0t: evicted expected %0d got %0d", $time, exp.evicted, got.evicted);
        errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $display("%0t: occupancy expected %0d got %0d", $time, exp.occupancy,
                 got.occupancy);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
// Top of the LRU key/value cache testbench: clock, reset, stream drivers,
// capacity writes and the watchdog. Depends on lkvc_pkg, lkvc_tb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import lkvc_pkg::*;
  import lkvc_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 103;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CAP_BITS-1:0]  cfg_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;   // key, value
  logic [OP_BITS-1:0]   s_axis_tuser;   // opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_TDATA-1:0] m_axis_tdata;   // found, result_value, evicted, occupancy, pad

  lru_mirror        cache_mirror;
  bit               quiet;              // no idling on either side
  logic [KEY_W-1:0] key_pool [24];
  int               pool_n;
  int               idle_cycles;

  lru_key_value_cache DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // One request beat; valid stays high straight into the next beat when no gap
  task automatic send_item(op_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_W'({v, k});
    do @(posedge clk); while (!s_axis_tready);
    cache_mirror.apply_request(op, k, v);
  endtask

  // Hold off until every owed result is back, then let the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (cache_mirror.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] c);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cache_mirror.set_capacity(c);
  endtask

  // Fresh key set sized a little past the capacity so gets and removes hit
  task automatic refresh_pool(logic [CAP_BITS-1:0] c);
    int eff;
    eff = (c == 0) ? 1 : (c > SLOTS) ? SLOTS : int'(c);
    pool_n = eff + 3;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
  endtask

  task automatic send_random();
    int               n;
    op_t              op;
    logic [KEY_W-1:0] k;
    n = $urandom_range(0, 99);
    if (n < 40) op = OP_PUT;
    else if (n < 75) op = OP_GET;
    else if (n < 95) op = OP_REM;
    else op = OP_NOP;
    if ($urandom_range(0, 19) == 0) k = {$urandom, $urandom};
    else k = key_pool[$urandom_range(0, pool_n - 1)];
    send_item(op, k, $urandom);
  endtask

  // Result side: random stall per beat, ready held high when none
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      cache_mirror.compare_response(m_axis_tdata);
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    logic [CAP_BITS-1:0] caps [PHASES];
    logic [KEY_W-1:0]    key_a;
    logic [KEY_W-1:0]    key_b;
    logic [KEY_W-1:0]    key_c;
    cache_mirror  = new();
    quiet         = 1'b0;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_NOP;
    key_a = 64'h0123_4567_89ab_cdef;
    key_b = 64'hfedc_ba98_7654_3210;
    key_c = 64'h8000_0000_0000_0001;
    caps  = '{5'd31, 5'd1, 5'd4, 5'd16, 5'd2, 5'd17, 5'd8, 5'd0, 5'd12,
              CAP_BITS'($urandom_range(0, 31))};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty cache misses, unused opcode, extreme keys and values
    send_item(OP_GET, '0, '0);
    send_item(OP_REM, '0, '0);
    send_item(OP_NOP, '1, '1);
    send_item(OP_PUT, '0, '0);
    send_item(OP_PUT, '1, '1);
    send_item(OP_GET, '0, '0);
    // duplicate puts: newest wins, removing it uncovers the older one
    send_item(OP_PUT, key_a, 32'd1);
    send_item(OP_PUT, key_a, 32'd2);
    send_item(OP_GET, key_a, '0);
    send_item(OP_REM, key_a, '0);
    send_item(OP_GET, key_a, '0);
    send_item(OP_REM, key_a, '0);
    send_item(OP_GET, key_a, '0);
    send_item(OP_REM, key_a, '0);
    // capacity of zero behaves as one, already below occupancy
    wait_idle();
    write_capacity(5'd0);
    send_item(OP_PUT, key_b, 32'd3);
    send_item(OP_PUT, key_c, 32'd4);
    send_item(OP_GET, key_b, '0);
    send_item(OP_GET, key_c, '0);
    // grow, then lower capacity under occupancy: put evicts only one
    wait_idle();
    write_capacity(5'd16);
    send_item(OP_PUT, key_a, 32'h5555_aaaa);
    send_item(OP_PUT, key_b, 32'haaaa_5555);
    send_item(OP_PUT, key_a, 32'h0f0f_f0f0);
    wait_idle();
    write_capacity(5'd2);
    send_item(OP_PUT, key_c, 32'h1234_5678);
    send_item(OP_REM, key_c, '0);
    send_item(OP_REM, '1, '0);

    // random phases, each under its own capacity
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_capacity(caps[p]);
      refresh_pool(caps[p]);
      quiet = (p % 4 == 3);
      repeat (PHASE_ITEMS) send_random();
    end
    quiet = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk);
    if (cache_mirror.errors == 0 && cache_mirror.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/lkvc_pkg.sv
hdl/lkvc_cell.sv
hdl/lru_key_value_cache.sv
hdl/lkvc_checker.sv
tb/lkvc_tb_pkg.sv
tb/tb_top.sv
